@@ src/hfm_pkg.sv @@
// ----------------------------------------------------------------------------
// hfm_pkg: shared types and tables for the heightfield triangle mesher
// Vertex and normal-unit transaction types, point selectors and the
// per-slot triangle corner table.
// ----------------------------------------------------------------------------
package hfm_pkg;

  // Default row store depth
  localparam int unsigned DEF_MAX_WIDTH = 4096;

  // Triangle slots handled per sample: cell, north, south, west, east, floor
  localparam int unsigned NUM_SLOTS = 12;
  localparam logic [3:0] SLOT_LAST = 4'd11;

  typedef enum logic [1:0] {
    ROLE_NORMAL = 2'd0,
    ROLE_A      = 2'd1,
    ROLE_B      = 2'd2,
    ROLE_C      = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_STEP        = 3'd2,
    REG_BASE_LEVEL  = 3'd3,
    REG_GAIN        = 3'd4,
    REG_WALLS       = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  // Normal unit request / response
  typedef struct packed {
    logic start;
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } nrm_req_t;

  typedef struct packed {
    logic done;
    vtx_t n;
  } nrm_rsp_t;

  // Point selectors: column, row and height source
  typedef enum logic [1:0] {XS_J1, XS_J, XS_0} xsel_e;
  typedef enum logic [1:0] {YS_I1, YS_I, YS_H} ysel_e;
  typedef enum logic [2:0] {ZS_0, ZS_AL, ZS_AR, ZS_L, ZS_C} zsel_e;

  typedef struct packed {
    xsel_e xs;
    ysel_e ys;
    zsel_e zs;
  } pt_t;

  typedef struct packed {
    pt_t a;
    pt_t b;
    pt_t c;
  } tri_t;

  function automatic pt_t mk_pt(xsel_e xs, ysel_e ys, zsel_e zs);
    pt_t p;
    p.xs = xs;
    p.ys = ys;
    p.zs = zs;
    return p;
  endfunction

  // Corner selection of each triangle slot, in output order
  function automatic tri_t tri_pts(logic [3:0] slot);
    pt_t  na, nb, nc, nb2, wa, wb, p0, p1, p2;
    tri_t t;
    na  = mk_pt(XS_J1, YS_I,  ZS_L);
    nb  = mk_pt(XS_J1, YS_I,  ZS_0);
    nc  = mk_pt(XS_J,  YS_I,  ZS_C);
    nb2 = mk_pt(XS_J,  YS_I,  ZS_0);
    wa  = mk_pt(XS_J,  YS_I1, ZS_AR);
    wb  = mk_pt(XS_J,  YS_I1, ZS_0);
    p0  = mk_pt(XS_0,  YS_H,  ZS_0);
    p1  = mk_pt(XS_J,  YS_H,  ZS_0);
    p2  = mk_pt(XS_0,  YS_I,  ZS_0);
    case (slot)
      4'd0: begin
        t.a = mk_pt(XS_J1, YS_I1, ZS_AL);
        t.b = mk_pt(XS_J1, YS_I, ZS_L);
        t.c = mk_pt(XS_J, YS_I1, ZS_AR);
      end
      4'd1: begin
        t.a = mk_pt(XS_J1, YS_I, ZS_L);
        t.b = mk_pt(XS_J, YS_I, ZS_C);
        t.c = mk_pt(XS_J, YS_I1, ZS_AR);
      end
      4'd2:  t = '{a: nb,  b: na,  c: nc};
      4'd3:  t = '{a: nb2, b: nb,  c: nc};
      4'd4:  t = '{a: na,  b: nb,  c: nc};
      4'd5:  t = '{a: nb,  b: nb2, c: nc};
      4'd6:  t = '{a: wa,  b: wb,  c: nc};
      4'd7:  t = '{a: wb,  b: nb2, c: nc};
      4'd8:  t = '{a: wb,  b: wa,  c: nc};
      4'd9:  t = '{a: nb2, b: wb,  c: nc};
      4'd10: t = '{a: p0,  b: p1,  c: p2};
      4'd11: t = '{a: p1,  b: nb2, c: p2};
      default: t = '{a: p0, b: p0, c: p0};
    endcase
    return t;
  endfunction

endpackage

@@ src/heightfield_triangle_mesher_unit.sv @@
// ----------------------------------------------------------------------------
// heightfield_triangle_mesher_unit: elevation grid to triangle stream
// Row store, coordinate and height prep, slot sequencer, output register.
// ----------------------------------------------------------------------------
// One sample is taken at a time; in_ready_o is high only while the block is
// idle. A sample passes through row-store reads, coordinate and height prep,
// a scan over the twelve triangle slots and write-back; each triangle that it
// produces (zero to eight) also goes through the normal unit, whose 32-step
// square root and three 62-step divisions dominate its work (it ends early
// when the cross product is zero), and is then handed out as the normal and
// the three vertices. Every triangle result
// is four transactions on the output channel, the last of a sample flagged by
// last_of_run_o. The row store needs no clearing pass after reset.
module heightfield_triangle_mesher_unit #(
  parameter int unsigned MAX_WIDTH = hfm_pkg::DEF_MAX_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] elevation_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         role_o,
  output logic signed [31:0] coord_x_o,
  output logic signed [31:0] coord_y_o,
  output logic signed [31:0] coord_z_o,
  output logic               last_of_run_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import hfm_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Prep operation indexes
  localparam logic [3:0] PRE_XJ1 = 4'd0;
  localparam logic [3:0] PRE_XJ  = 4'd1;
  localparam logic [3:0] PRE_YI1 = 4'd2;
  localparam logic [3:0] PRE_YI  = 4'd3;
  localparam logic [3:0] PRE_YH  = 4'd4;
  localparam logic [3:0] PRE_ZAL = 4'd5;
  localparam logic [3:0] PRE_ZAR = 4'd6;
  localparam logic [3:0] PRE_ZL  = 4'd7;
  localparam logic [3:0] PRE_ZC  = 4'd8;
  localparam logic [3:0] PRE_END = 4'd9;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_PRE, S_SEL, S_NRM, S_EMIT, S_WB0, S_WB1
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      col_q;
  logic [15:0]        row_q;
  logic [3:0]         pk_q;
  logic [3:0]         slot_q;
  role_e              role_q;
  logic               out_valid_q;
  logic signed [31:0] left_q;

  logic [12:0]        gw_q;
  logic [15:0]        gh_q;
  logic [23:0]        step_q;
  logic signed [31:0] base_q;
  logic [23:0]        gain_q;
  logic               walls_q;

  logic [31:0]        row_store_q [MAX_WIDTH];
  logic [31:0]        rdata_q;
  logic signed [31:0] s_q, raw_al_q, raw_ar_q;
  logic [55:0]        prod_q;
  logic               dpos_q;
  logic [31:0]        pre_q [9];

  role_e              out_role_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic               out_last_q;

  logic               in_acc, cfg_we, out_load, later;
  logic [31:0]        gw_ext, wm1_full;
  logic [CW-1:0]      wm1, colm1;
  logic [15:0]        hh, hm1;
  logic [CW-1:0]      rd_addr, waddr;
  logic               mem_we;
  logic [31:0]        wdata, op_a, post;
  logic [23:0]        op_b;
  logic signed [31:0] smp;
  logic [32:0]        dd;
  logic               op_dpos;
  logic [3:0]         prev_k;
  logic [11:0]        mask;
  tri_t               tri_sel;
  vtx_t               va, vb, vc;
  nrm_req_t           nrm_req;
  nrm_rsp_t           nrm_rsp;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Effective grid size
  assign gw_ext   = {19'b0, gw_q};
  assign wm1_full = (gw_ext < 32'd2) ? 32'd1 :
                    ((gw_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : gw_ext - 32'd1);
  assign wm1      = wm1_full[CW-1:0];
  assign hh       = (gh_q < 16'd2) ? 16'd2 : gh_q;
  assign hm1      = hh - 16'd1;
  assign colm1    = col_q - CW'(1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= 13'd2;
      gh_q    <= 16'd2;
      step_q  <= 24'd256;
      base_q  <= '0;
      gain_q  <= 24'd65536;
      walls_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  gw_q    <= cfg_data_i[12:0];
        REG_GRID_HEIGHT: gh_q    <= cfg_data_i[15:0];
        REG_STEP:        step_q  <= cfg_data_i[23:0];
        REG_BASE_LEVEL:  base_q  <= $signed(cfg_data_i);
        REG_GAIN:        gain_q  <= cfg_data_i[23:0];
        REG_WALLS:       walls_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Row store: one read and one write port
  assign rd_addr = (state_q == S_RD0) ? colm1 : col_q;
  assign mem_we  = ((state_q == S_WB0) && (col_q != '0)) ||
                   ((state_q == S_WB1) && (col_q == wm1));
  assign waddr   = (state_q == S_WB0) ? colm1 : col_q;
  assign wdata   = (state_q == S_WB0) ? left_q : s_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) row_store_q[waddr] <= wdata;
    rdata_q <= row_store_q[rd_addr];
  end

  // Prep operands: coordinates use step, heights use gain
  always_comb begin
    case (pk_q)
      PRE_ZAL: smp = raw_al_q;
      PRE_ZAR: smp = raw_ar_q;
      PRE_ZL:  smp = left_q;
      default: smp = s_q;
    endcase
    dd      = {smp[31], smp} - {base_q[31], base_q};
    op_dpos = !dd[32] && (|dd[31:0]);
    case (pk_q)
      PRE_XJ1: op_a = 32'(colm1);
      PRE_XJ:  op_a = 32'(col_q);
      PRE_YI1: op_a = 32'({1'b0, hh} - {1'b0, row_q} + 17'd1);
      PRE_YI:  op_a = 32'({1'b0, hh} - {1'b0, row_q});
      PRE_YH:  op_a = 32'(hh);
      default: op_a = dd[31:0];
    endcase
    op_b = (pk_q < PRE_ZAL) ? step_q : gain_q;
  end

  // Saturation of the registered product
  assign prev_k = pk_q - 4'd1;
  always_comb begin
    if (prev_k < PRE_ZAL) begin
      post = (|prod_q[55:31]) ? 32'h7FFF_FFFF : {1'b0, prod_q[30:0]};
    end else if (!dpos_q) begin
      post = '0;
    end else begin
      post = (|prod_q[55:47]) ? 32'h7FFF_FFFF : {1'b0, prod_q[46:16]};
    end
  end

  // Prep datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) s_q <= elevation_i;
    if (state_q == S_RD1) raw_al_q <= $signed(rdata_q);
    if (state_q == S_PRE) begin
      if (pk_q == PRE_XJ1) raw_ar_q <= $signed(rdata_q);
      prod_q <= 56'(op_a) * 56'(op_b);
      dpos_q <= op_dpos;
      if (pk_q != PRE_XJ1) pre_q[prev_k] <= post;
    end
  end

  // Triangle slots active for this sample
  always_comb begin
    logic quad, north, south, west, east, floor_t;
    quad    = (row_q != '0) && (col_q != '0);
    north   = walls_q && (col_q != '0) && (row_q == '0);
    south   = walls_q && (col_q != '0) && (row_q == hm1);
    west    = walls_q && (row_q != '0) && (col_q == '0);
    east    = walls_q && (row_q != '0) && (col_q == wm1);
    floor_t = walls_q && (row_q == hm1) && (col_q == wm1);
    mask    = {floor_t, floor_t, east, east, west, west,
               south, south, north, north, quad, quad};
  end

  assign later = |(mask & ~((12'd2 << slot_q) - 12'd1));

  // Corner values of the current slot
  function automatic vtx_t pick(pt_t p, logic [31:0] xj1, logic [31:0] xj,
                                logic [31:0] yi1, logic [31:0] yi, logic [31:0] yh,
                                logic [31:0] zal, logic [31:0] zar,
                                logic [31:0] zl, logic [31:0] zc);
    vtx_t v;
    case (p.xs)
      XS_J1:   v.x = $signed(xj1);
      XS_J:    v.x = $signed(xj);
      default: v.x = '0;
    endcase
    case (p.ys)
      YS_I1:   v.y = $signed(yi1);
      YS_I:    v.y = $signed(yi);
      default: v.y = $signed(yh);
    endcase
    case (p.zs)
      ZS_AL:   v.z = $signed(zal);
      ZS_AR:   v.z = $signed(zar);
      ZS_L:    v.z = $signed(zl);
      ZS_C:    v.z = $signed(zc);
      default: v.z = '0;
    endcase
    return v;
  endfunction

  assign tri_sel = tri_pts(slot_q);
  assign va = pick(tri_sel.a, pre_q[0], pre_q[1], pre_q[2], pre_q[3], pre_q[4],
                   pre_q[5], pre_q[6], pre_q[7], pre_q[8]);
  assign vb = pick(tri_sel.b, pre_q[0], pre_q[1], pre_q[2], pre_q[3], pre_q[4],
                   pre_q[5], pre_q[6], pre_q[7], pre_q[8]);
  assign vc = pick(tri_sel.c, pre_q[0], pre_q[1], pre_q[2], pre_q[3], pre_q[4],
                   pre_q[5], pre_q[6], pre_q[7], pre_q[8]);

  // Normal unit
  assign nrm_req.start = (state_q == S_SEL) && mask[slot_q];
  assign nrm_req.a     = va;
  assign nrm_req.b     = vb;
  assign nrm_req.c     = vc;

  hfm_normal u_normal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nrm_req),
    .rsp_o  (nrm_rsp)
  );

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Sample sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      pk_q        <= '0;
      slot_q      <= '0;
      role_q      <= ROLE_NORMAL;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we && (cfg_index_i inside {REG_GRID_WIDTH, REG_GRID_HEIGHT})) begin
            col_q <= '0;
            row_q <= '0;
          end
          if (in_acc) begin
            // restart the frame if a counter is out of range
            if ((col_q > wm1) || (row_q > hm1)) begin
              col_q <= '0;
              row_q <= '0;
            end
            state_q <= S_RD0;
          end
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          pk_q    <= '0;
          state_q <= S_PRE;
        end
        S_PRE: begin
          pk_q <= pk_q + 4'd1;
          if (pk_q == PRE_END) begin
            slot_q  <= '0;
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          if (mask[slot_q]) state_q <= S_NRM;
          else if (slot_q == SLOT_LAST) state_q <= S_WB0;
          else slot_q <= slot_q + 4'd1;
        end
        S_NRM: begin
          if (nrm_rsp.done) begin
            role_q  <= ROLE_NORMAL;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            role_q <= role_e'(role_q + 2'd1);
            if (role_q == ROLE_C) begin
              if (slot_q == SLOT_LAST) begin
                state_q <= S_WB0;
              end else begin
                slot_q  <= slot_q + 4'd1;
                state_q <= S_SEL;
              end
            end
          end
        end
        S_WB0: state_q <= S_WB1;
        S_WB1: begin
          left_q <= s_q;
          if (col_q == wm1) begin
            col_q <= '0;
            row_q <= (row_q == hm1) ? 16'd0 : row_q + 16'd1;
          end else begin
            col_q <= col_q + CW'(1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_role_q <= role_q;
      out_last_q <= (role_q == ROLE_C) && !later;
      case (role_q)
        ROLE_NORMAL: begin
          out_x_q <= nrm_rsp.n.x; out_y_q <= nrm_rsp.n.y; out_z_q <= nrm_rsp.n.z;
        end
        ROLE_A: begin
          out_x_q <= va.x; out_y_q <= va.y; out_z_q <= va.z;
        end
        ROLE_B: begin
          out_x_q <= vb.x; out_y_q <= vb.y; out_z_q <= vb.z;
        end
        default: begin
          out_x_q <= vc.x; out_y_q <= vc.y; out_z_q <= vc.z;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign role_o        = out_role_q;
  assign coord_x_o     = out_x_q;
  assign coord_y_o     = out_y_q;
  assign coord_z_o     = out_z_q;
  assign last_of_run_o = out_last_q;

  // Counters stay inside the grid while a sample is worked on
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ((col_q <= wm1) && (row_q <= hm1)))
    else $error("grid counter out of range during a sample");

  // Normal unit finishes only while the sequencer waits for it
  a_nrm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm_rsp.done |-> (state_q == S_NRM))
    else $error("normal unit done outside of wait state");

  // End-of-run flag only on a vertex C transaction
  a_last_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (role_o == ROLE_C))
    else $error("last_of_run on a non-final role");

endmodule

@@ src/hfm_normal.sv @@
// ----------------------------------------------------------------------------
// hfm_normal: iterative unit normal of one triangle
// Cross product on a shared 32x32 multiplier, bit-per-cycle normalization,
// bit-serial square root and three restoring divisions, all sequenced.
// ----------------------------------------------------------------------------
module hfm_normal (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hfm_pkg::nrm_req_t req_i,
  output hfm_pkg::nrm_rsp_t rsp_o
);
  import hfm_pkg::*;

  typedef enum logic [3:0] {
    N_IDLE, N_MUL, N_ACC, N_ABS, N_MAX, N_SHIFT, N_SQM, N_SQA,
    N_ROOT, N_DINI, N_DIV, N_SGN, N_DONE
  } nstate_e;

  nstate_e            state_q;
  logic [5:0]         cnt_q;
  logic [1:0]         kidx_q;
  logic               zero_q;

  logic signed [31:0] d_q [6];
  logic signed [63:0] cr_q [3];
  logic [62:0]        cm_q [3];
  logic [2:0]         neg_q;
  logic [62:0]        m_q;
  logic signed [63:0] prod_q;
  logic [63:0]        sum_q, res_q, rbit_q;
  logic [61:0]        num_q;
  logic [31:0]        rem_q, quo_q;
  logic signed [31:0] nrm_q [3];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [62:0]        cm_sel, cm_k, max01, max012;
  logic [63:0]        root_try;
  logic               root_ge;
  logic [32:0]        div_sh, div_sub;
  logic               div_ge;

  // Shared multiplier operand selection
  always_comb begin
    cm_sel = cm_q[2];
    case (cnt_q[1:0])
      2'd0:    cm_sel = cm_q[0];
      2'd1:    cm_sel = cm_q[1];
      default: cm_sel = cm_q[2];
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      N_MUL: begin
        case (cnt_q[2:0])
          3'd0:    begin mul_a = d_q[1]; mul_b = d_q[5]; end
          3'd1:    begin mul_a = d_q[2]; mul_b = d_q[4]; end
          3'd2:    begin mul_a = d_q[2]; mul_b = d_q[3]; end
          3'd3:    begin mul_a = d_q[0]; mul_b = d_q[5]; end
          3'd4:    begin mul_a = d_q[0]; mul_b = d_q[4]; end
          default: begin mul_a = d_q[1]; mul_b = d_q[3]; end
        endcase
      end
      N_SQM: begin
        mul_a = $signed({1'b0, cm_sel[30:0]});
        mul_b = $signed({1'b0, cm_sel[30:0]});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Component picked for the division
  always_comb begin
    case (kidx_q)
      2'd0:    cm_k = cm_q[0];
      2'd1:    cm_k = cm_q[1];
      default: cm_k = cm_q[2];
    endcase
  end

  // Largest cross product magnitude
  assign max01  = (cm_q[0] > cm_q[1]) ? cm_q[0] : cm_q[1];
  assign max012 = (max01 > cm_q[2]) ? max01 : cm_q[2];

  // Square root step
  assign root_try = res_q + rbit_q;
  assign root_ge  = sum_q >= root_try;

  // Division step
  assign div_sh  = {rem_q, num_q[61]};
  assign div_ge  = div_sh >= {1'b0, res_q[31:0]};
  assign div_sub = div_sh - {1'b0, res_q[31:0]};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      kidx_q  <= '0;
    end else begin
      case (state_q)
        N_IDLE: begin
          if (req_i.start) begin
            cnt_q   <= '0;
            state_q <= N_MUL;
          end
        end
        N_MUL: state_q <= N_ACC;
        N_ACC: begin
          if (cnt_q == 6'd5) begin
            state_q <= N_ABS;
          end else begin
            cnt_q   <= cnt_q + 6'd1;
            state_q <= N_MUL;
          end
        end
        N_ABS: state_q <= N_MAX;
        N_MAX: state_q <= (max012 == '0) ? N_DONE : N_SHIFT;
        N_SHIFT: begin
          if (!(|m_q[62:31]) && m_q[30]) begin
            cnt_q   <= '0;
            state_q <= N_SQM;
          end
        end
        N_SQM: state_q <= N_SQA;
        N_SQA: begin
          if (cnt_q == 6'd2) begin
            cnt_q   <= '0;
            state_q <= N_ROOT;
          end else begin
            cnt_q   <= cnt_q + 6'd1;
            state_q <= N_SQM;
          end
        end
        N_ROOT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            kidx_q  <= '0;
            state_q <= N_DINI;
          end
        end
        N_DINI: begin
          cnt_q   <= '0;
          state_q <= N_DIV;
        end
        N_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd61) state_q <= N_SGN;
        end
        N_SGN: begin
          if (kidx_q == 2'd2) begin
            state_q <= N_DONE;
          end else begin
            kidx_q  <= kidx_q + 2'd1;
            state_q <= N_DINI;
          end
        end
        N_DONE:  state_q <= N_IDLE;
        default: state_q <= N_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (req_i.start) begin
          d_q[0] <= req_i.b.x - req_i.a.x;
          d_q[1] <= req_i.b.y - req_i.a.y;
          d_q[2] <= req_i.b.z - req_i.a.z;
          d_q[3] <= req_i.c.x - req_i.a.x;
          d_q[4] <= req_i.c.y - req_i.a.y;
          d_q[5] <= req_i.c.z - req_i.a.z;
        end
      end
      N_MUL: prod_q <= mul_p;
      N_ACC: begin
        case (cnt_q[2:1])
          2'd0:    cr_q[0] <= cnt_q[0] ? (cr_q[0] - prod_q) : prod_q;
          2'd1:    cr_q[1] <= cnt_q[0] ? (cr_q[1] - prod_q) : prod_q;
          default: cr_q[2] <= cnt_q[0] ? (cr_q[2] - prod_q) : prod_q;
        endcase
      end
      N_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= cr_q[k][63];
          cm_q[k]  <= cr_q[k][63] ? 63'(-cr_q[k]) : cr_q[k][62:0];
        end
      end
      N_MAX: begin
        m_q    <= max012;
        zero_q <= (max012 == '0);
      end
      N_SHIFT: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (|m_q[62:31]) begin
          m_q <= m_q >> 1;
          for (int k = 0; k < 3; k++) cm_q[k] <= cm_q[k] >> 1;
        end else if (!m_q[30]) begin
          m_q <= m_q << 1;
          for (int k = 0; k < 3; k++) cm_q[k] <= cm_q[k] << 1;
        end
      end
      N_SQM: prod_q <= mul_p;
      N_SQA: begin
        sum_q  <= ((cnt_q == 6'd0) ? 64'd0 : sum_q) + 64'(prod_q);
        res_q  <= '0;
        rbit_q <= 64'd1 << 62;
      end
      N_ROOT: begin
        if (root_ge) begin
          sum_q <= sum_q - root_try;
          res_q <= (res_q >> 1) + rbit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        rbit_q <= rbit_q >> 2;
      end
      N_DINI: begin
        // rounded numerator (c << 30) + r / 2
        num_q <= {1'b0, cm_k[30:0], 30'b0} + 62'(res_q[31:1]);
        rem_q <= '0;
        quo_q <= '0;
      end
      N_DIV: begin
        rem_q <= div_ge ? div_sub[31:0] : div_sh[31:0];
        quo_q <= {quo_q[30:0], div_ge};
        num_q <= num_q << 1;
      end
      N_SGN: begin
        case (kidx_q)
          2'd0:    nrm_q[0] <= neg_q[0] ? -$signed(quo_q) : $signed(quo_q);
          2'd1:    nrm_q[1] <= neg_q[1] ? -$signed(quo_q) : $signed(quo_q);
          default: nrm_q[2] <= neg_q[2] ? -$signed(quo_q) : $signed(quo_q);
        endcase
      end
      default: ;
    endcase
  end

  // Zero cross product gives a zero normal
  assign rsp_o.done = (state_q == N_DONE);
  assign rsp_o.n.x  = zero_q ? '0 : nrm_q[0];
  assign rsp_o.n.y  = zero_q ? '0 : nrm_q[1];
  assign rsp_o.n.z  = zero_q ? '0 : nrm_q[2];

endmodule

@@ sim/hfm_checker.sv @@
// ----------------------------------------------------------------------------
// hfm_checker: result predictor and scoreboard for the triangle mesher
// Watches the config, sample and result channels. Every accepted sample is
// run through a local model of the mesher; every accepted result is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module hfm_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] elevation_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         role_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic               last_of_run_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int unsigned        err_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  import hfm_pkg::*;

  typedef struct {
    role_e              role;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } facet_word_t;

  facet_word_t mesh_expected_q[$];

  // Local copy of block state
  logic [31:0]        row_mem [0:DEF_MAX_WIDTH-1];
  logic signed [31:0] left_elev;
  int unsigned        col_cnt;
  int unsigned        row_cnt;

  // Local copy of configuration
  logic [12:0]        width_r;
  logic [15:0]        height_r;
  logic [23:0]        step_r;
  logic signed [31:0] base_r;
  logic [23:0]        gain_r;
  logic               walls_r;

  assign pending_o = mesh_expected_q.size();

  function automatic int unsigned grid_w();
    if (width_r < 2) return 2;
    return (width_r > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_r;
  endfunction

  function automatic int unsigned grid_h();
    return (height_r < 2) ? 2 : height_r;
  endfunction

  function automatic logic signed [31:0] clip_pos(logic [63:0] v);
    return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
  endfunction

  // z = max(0, (s - base) * gain) >> 16, saturated
  function automatic logic signed [31:0] scaled_height(logic signed [31:0] s);
    longint     d;
    logic [63:0] p;
    d = longint'(s) - longint'(base_r);
    if (d <= 0) return 0;
    p = 64'(d) * {40'd0, gain_r};
    return clip_pos(p >> 16);
  endfunction

  function automatic vtx_t grid_point(int unsigned col, int unsigned row,
                                      logic signed [31:0] z);
    vtx_t p;
    p.x = clip_pos(64'(col) * {40'd0, step_r});
    p.y = clip_pos(64'(grid_h() - row) * {40'd0, step_r});
    p.z = z;
    return p;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void push_word(role_e r, logic signed [31:0] x,
                                    logic signed [31:0] y, logic signed [31:0] z);
    facet_word_t w;
    w.role = r;
    w.x = x;
    w.y = y;
    w.z = z;
    w.last = 1'b0;
    mesh_expected_q.push_back(w);
  endfunction

  // Unit normal then three corners
  function automatic void push_facet(vtx_t a, vtx_t b, vtx_t c);
    longint             d [6];
    longint             cr [3];
    logic [63:0]        cm [3];
    logic [63:0]        m, sum, r, q;
    logic signed [31:0] nv [3];
    int unsigned        sh;
    d[0] = longint'(b.x) - longint'(a.x);
    d[1] = longint'(b.y) - longint'(a.y);
    d[2] = longint'(b.z) - longint'(a.z);
    d[3] = longint'(c.x) - longint'(a.x);
    d[4] = longint'(c.y) - longint'(a.y);
    d[5] = longint'(c.z) - longint'(a.z);
    m = 0;
    for (int k = 0; k < 6; k++) if (abs64(d[k]) > m) m = abs64(d[k]);
    sh = 0;
    while ((m >> sh) > 64'h7FFF_FFFF) sh++;
    for (int k = 0; k < 6; k++) begin
      if (d[k] < 0) d[k] = -longint'(abs64(d[k]) >> sh);
      else d[k] = longint'(abs64(d[k]) >> sh);
    end
    cr[0] = d[1] * d[5] - d[2] * d[4];
    cr[1] = d[2] * d[3] - d[0] * d[5];
    cr[2] = d[0] * d[4] - d[1] * d[3];
    m = 0;
    for (int k = 0; k < 3; k++) begin
      cm[k] = abs64(cr[k]);
      if (cm[k] > m) m = cm[k];
      nv[k] = 0;
    end
    // degenerate triangle keeps the zero normal
    if (m != 0) begin
      while (m >= (64'd1 << 31)) begin
        m = m >> 1;
        for (int k = 0; k < 3; k++) cm[k] = cm[k] >> 1;
      end
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int k = 0; k < 3; k++) cm[k] = cm[k] << 1;
      end
      sum = cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2];
      r = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
        q = ((cm[k] << 30) + (r >> 1)) / r;
        nv[k] = (cr[k] < 0) ? -q[31:0] : q[31:0];
      end
    end
    push_word(ROLE_NORMAL, nv[0], nv[1], nv[2]);
    push_word(ROLE_A, a.x, a.y, a.z);
    push_word(ROLE_B, b.x, b.y, b.z);
    push_word(ROLE_C, c.x, c.y, c.z);
  endfunction

  // Predict everything one sample produces and advance the grid position
  function automatic void mesh_sample(logic signed [31:0] s);
    int unsigned        w, h, i, j, start;
    logic signed [31:0] zal, zar, zl, zc;
    vtx_t               a, b, c, b2, p0, p1, p2, p3;
    w = grid_w();
    h = grid_h();
    start = mesh_expected_q.size();
    if (col_cnt >= w || row_cnt >= h) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    i = row_cnt;
    j = col_cnt;
    zl = scaled_height(left_elev);
    zc = scaled_height(s);
    zar = scaled_height(row_mem[j]);
    if (i >= 1 && j >= 1) begin
      zal = scaled_height(row_mem[j-1]);
      push_facet(grid_point(j-1, i-1, zal), grid_point(j-1, i, zl), grid_point(j, i-1, zar));
      push_facet(grid_point(j-1, i, zl), grid_point(j, i, zc), grid_point(j, i-1, zar));
    end
    if (walls_r) begin
      // north and south walls
      if (j >= 1 && (i == 0 || i == h - 1)) begin
        a = grid_point(j-1, i, zl);
        b = grid_point(j-1, i, 0);
        c = grid_point(j, i, zc);
        b2 = grid_point(j, i, 0);
        if (i == 0) begin
          push_facet(b, a, c);
          push_facet(b2, b, c);
        end
        if (i == h - 1) begin
          push_facet(a, b, c);
          push_facet(b, b2, c);
        end
      end
      // west and east walls
      if (i >= 1 && (j == 0 || j == w - 1)) begin
        a = grid_point(j, i-1, zar);
        b = grid_point(j, i-1, 0);
        c = grid_point(j, i, zc);
        b2 = grid_point(j, i, 0);
        if (j == 0) begin
          push_facet(a, b, c);
          push_facet(b, b2, c);
        end
        if (j == w - 1) begin
          push_facet(b, a, c);
          push_facet(b2, b, c);
        end
      end
      // floor after the last sample
      if (i == h - 1 && j == w - 1) begin
        p0 = grid_point(0, 0, 0);
        p1 = grid_point(w-1, 0, 0);
        p2 = grid_point(0, h-1, 0);
        p3 = grid_point(w-1, h-1, 0);
        push_facet(p0, p1, p2);
        push_facet(p1, p3, p2);
      end
    end
    if (j >= 1) row_mem[j-1] = left_elev;
    left_elev = s;
    if (j == w - 1) row_mem[j] = s;
    col_cnt = j + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = i + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    if (mesh_expected_q.size() > start)
      mesh_expected_q[mesh_expected_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    facet_word_t e;
    if (!rst_ni) begin
      width_r <= 13'd2;
      height_r <= 16'd2;
      step_r <= 24'd256;
      base_r <= '0;
      gain_r <= 24'd65536;
      walls_r <= 1'b0;
      left_elev = '0;
      col_cnt = 0;
      row_cnt = 0;
      for (int k = 0; k < DEF_MAX_WIDTH; k++) row_mem[k] = '0;
      err_count_o <= 0;
      checked_o <= 0;
    end else begin
      // config transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_GRID_WIDTH: begin
            width_r <= cfg_data_i[12:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          REG_GRID_HEIGHT: begin
            height_r <= cfg_data_i[15:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          REG_STEP:       step_r <= cfg_data_i[23:0];
          REG_BASE_LEVEL: base_r <= cfg_data_i;
          REG_GAIN:       gain_r <= cfg_data_i[23:0];
          REG_WALLS:      walls_r <= cfg_data_i[0];
          default: ;
        endcase
      end
      // sample transaction
      if (in_valid_i && in_ready_i) mesh_sample(elevation_i);
      // result transaction
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (mesh_expected_q.size() == 0) begin
          $error("unexpected result: role %0d x %0d y %0d z %0d",
                 role_i, coord_x_i, coord_y_i, coord_z_i);
          err_count_o <= err_count_o + 1;
        end else begin
          e = mesh_expected_q.pop_front();
          if (role_i !== e.role || coord_x_i !== e.x || coord_y_i !== e.y ||
              coord_z_i !== e.z || last_of_run_i !== e.last) begin
            err_count_o <= err_count_o + 1;
            if (role_i !== e.role)
              $error("role: expected %0d, got %0d", e.role, role_i);
            if (coord_x_i !== e.x)
              $error("coord_x: expected %0d, got %0d", e.x, coord_x_i);
            if (coord_y_i !== e.y)
              $error("coord_y: expected %0d, got %0d", e.y, coord_y_i);
            if (coord_z_i !== e.z)
              $error("coord_z: expected %0d, got %0d", e.z, coord_z_i);
            if (last_of_run_i !== e.last)
              $error("last_of_run: expected %0d, got %0d", e.last, last_of_run_i);
          end
        end
      end
    end
  end

endmodule

@@ sim/heightfield_triangle_mesher_unit_test.sv @@
// ----------------------------------------------------------------------------
// heightfield_triangle_mesher_unit_test: stimulus and verdict for the mesher
// Drives directed and random elevation grids under several geometry and
// scaling settings, with random stalls on both channels; hfm_checker
// predicts and compares the triangle stream.
// ----------------------------------------------------------------------------
module heightfield_triangle_mesher_unit_test;
  import hfm_pkg::*;

  localparam int unsigned TARGET_SAMPLES = 330;
  localparam longint      CYCLE_LIMIT = 6_000_000;
  localparam logic [2:0]  REG_SPARE = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] elevation;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         role;
  logic signed [31:0] coord_x, coord_y, coord_z;
  logic               last_of_run;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int unsigned        err_count, pending, checked;

  int unsigned        samples_sent;
  int unsigned        settings_used;
  logic               quiet;
  logic signed [31:0] cur_base;
  longint             cycles;

  heightfield_triangle_mesher_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .elevation_i(elevation),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .role_o(role),
    .coord_x_o(coord_x), .coord_y_o(coord_y), .coord_z_o(coord_z),
    .last_of_run_o(last_of_run),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  hfm_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .elevation_i(elevation),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .role_i(role),
    .coord_x_i(coord_x), .coord_y_i(coord_y), .coord_z_i(coord_z),
    .last_of_run_i(last_of_run),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .err_count_o(err_count), .pending_o(pending), .checked_o(checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result-side backpressure in random bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (!quiet && $urandom_range(0, 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
  end

  // one sample transaction; valid stays high for back-to-back samples
  task automatic send_sample(logic signed [31:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    elevation <= v;
    // ready only moves at a rising edge, so look at it between edges
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  // wait for all results, then let a zero-result sample finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [12:0] w, logic [15:0] h, logic [23:0] st,
                               logic signed [31:0] base, logic [23:0] g, logic walls);
    drain();
    cfg_write(REG_GRID_WIDTH, {19'd0, w});
    cfg_write(REG_GRID_HEIGHT, {16'd0, h});
    cfg_write(REG_STEP, {8'd0, st});
    cfg_write(REG_BASE_LEVEL, base);
    cfg_write(REG_GAIN, {8'd0, g});
    cfg_write(REG_WALLS, {31'd0, walls});
    cfg_valid <= 1'b0;
    cur_base = base;
    settings_used++;
  endtask

  function automatic logic signed [31:0] pick_elevation();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return cur_base + $signed($urandom_range(0, 8192));
      2: return cur_base - $signed($urandom_range(0, 8192));
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return cur_base + $signed($urandom_range(0, 1 << 20));
    endcase
  endfunction

  initial begin
    int unsigned w, h, n, pause_at;
    logic [23:0] st, g;
    logic signed [31:0] base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    elevation = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    samples_sent = 0;
    settings_used = 0;
    cur_base = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: one 2x2 cell with extreme samples
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'shFFFF_FFFF);

    // zero spacing: every triangle degenerate, zero normals
    apply_setting(13'd2, 16'd2, 24'd0, 32'sd0, 24'd65536, 1'b1);
    repeat (4) send_sample($urandom);

    // 3x3 with walls: every wall, corner and the floor
    apply_setting(13'd3, 16'd3, 24'd256, 32'sd0, 24'd65536, 1'b1);
    send_sample(32'sd256);
    send_sample(32'sd512);
    send_sample(-32'sd100);
    send_sample(32'sd0);
    send_sample(32'sd1024);
    send_sample(32'sd300);
    send_sample(32'sd77);
    send_sample(32'sh0FFF_FFFF);
    send_sample(32'sd1);

    // saturation: largest step and gain, lowest base
    apply_setting(13'd2, 16'd2, 24'hFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF, 1'b1);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0100);
    send_sample(32'sh7FFF_0000);

    // widest clamped row and tallest grid, only the first row: no output
    apply_setting(13'h1FFF, 16'hFFFF, 24'd256, 32'sh7FFF_FFFF, 24'd0, 1'b0);
    drain();
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    repeat (12) send_sample($urandom);

    // below-range geometry clamps to 2x2
    apply_setting(13'd0, 16'd0, 24'd1, -32'sd1000, 24'd1, 1'b1);
    repeat (8) send_sample(pick_elevation());

    // random grids: mostly whole frames, some broken frames
    pause_at = $urandom_range(120, 200);
    while (samples_sent < TARGET_SAMPLES) begin
      w = $urandom_range(2, 5);
      h = $urandom_range(2, 4);
      st = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 2048));
      g = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(1 << 14, 1 << 18));
      base = $urandom_range(0, 3) == 0 ? $signed($urandom) : $signed($urandom_range(0, 4096)) - 2048;
      apply_setting(w[12:0], h[15:0], st, base, g, $urandom_range(0, 2) != 0);
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = n + $urandom_range(1, w * h - 1);
      if (samples_sent > TARGET_SAMPLES - 50) quiet = 1'b1;
      repeat (n) begin
        if (samples_sent == pause_at) drain();
        send_sample(pick_elevation());
      end
    end

    // wrap up
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    $display("Ran %0d samples over %0d settings, %0d results checked.",
             samples_sent, settings_used, checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
